@@ sv/psmzc_pkg.sv @@
// Package for the pulse-skipping zero-cross dimmer core.
// Holds the result record, register indexes, reset values and mains period limits.
// No dependencies.
package psmzc_pkg;

  // Configuration register indexes
  localparam logic CFG_DEBOUNCE_US  = 1'b0;
  localparam logic CFG_MAX_RESTARTS = 1'b1;

  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [15:0] DEBOUNCE_US_RST  = 16'd15000;
  localparam logic [3:0]  MAX_RESTARTS_RST = 4'd5;

  // Mean-period windows in microseconds (inclusive)
  localparam int unsigned MIN_50HZ_PERIOD = 18182;
  localparam int unsigned MAX_50HZ_PERIOD = 22222;
  localparam int unsigned MIN_60HZ_PERIOD = 15385;
  localparam int unsigned MAX_60HZ_PERIOD = 18181;

  localparam logic [7:0] PERCENT_FULL  = 8'd100;
  localparam logic [3:0] RESTART_LIMIT = 4'hF;

  typedef struct packed {
    logic gate_on;
    logic freq_known;
    logic mains_60hz;
    logic detect_gave_up;
  } result_t;

endpackage

@@ sv/psm_zero_cross_dimmer_core.sv @@
// Top level of the pulse-skipping zero-cross dimmer core.
// Depends on psmzc_pkg for the result record, register indexes and limits.
//
// One request per zero crossing; the core takes a request every cycle while
// in_ready is high. All state (debounce time base, period sum, restart count,
// percent accumulator) updates in the cycle of acceptance.
// Crossings closer than debounce_us to the last accepted one give no result.
// Results pass through a two-entry output buffer (output register plus skid),
// so in_ready only drops while both entries hold results. The mean mains
// period is never divided out: the sum of PERIODS_TO_AVERAGE periods is
// compared against the window limits scaled by that count. cfg_ready is
// always high; write registers only while the core is idle.
module psm_zero_cross_dimmer_core #(
  parameter int unsigned PERIODS_TO_AVERAGE = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  // crossing requests
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_timestamp_us,
  input  logic [6:0]  in_power_percent,
  input  logic        in_enable,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_gate_on,
  output logic        out_freq_known,
  output logic        out_mains_60hz,
  output logic        out_detect_gave_up,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [psmzc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CntW = $clog2(PERIODS_TO_AVERAGE + 1);
  localparam logic [CntW-1:0] CntTarget = CntW'(PERIODS_TO_AVERAGE);
  // Sum limits: lower bound inclusive, upper bound exclusive
  localparam logic [31:0] Sum50Lo = 32'(psmzc_pkg::MIN_50HZ_PERIOD * PERIODS_TO_AVERAGE);
  localparam logic [31:0] Sum50Hi =
    32'((psmzc_pkg::MAX_50HZ_PERIOD + 1) * PERIODS_TO_AVERAGE);
  localparam logic [31:0] Sum60Lo = 32'(psmzc_pkg::MIN_60HZ_PERIOD * PERIODS_TO_AVERAGE);
  localparam logic [31:0] Sum60Hi =
    32'((psmzc_pkg::MAX_60HZ_PERIOD + 1) * PERIODS_TO_AVERAGE);

  // configuration
  logic [15:0]     debounce_us_r;
  logic [3:0]      max_restarts_r;

  // core state
  logic [31:0]     last_crossing_r, last_crossing_nxt;
  logic [6:0]      acc_r, acc_nxt;
  logic            prev_enable_r;
  logic [31:0]     period_sum_r, period_sum_nxt;
  logic [CntW-1:0] period_count_r, period_count_nxt;
  logic [3:0]      restart_count_r, restart_count_nxt;
  logic            freq_known_r, freq_known_nxt;
  logic            is_60hz_r, is_60hz_nxt;

  // output buffer
  logic                out_valid_r, skid_valid_r;
  psmzc_pkg::result_t  out_data_r, skid_data_r, res;

  logic        in_fire, push, pop;
  logic        pass;
  logic [31:0] gap_us;
  logic [31:0] sum_add;
  logic [CntW-1:0] cnt_add;
  logic [6:0]  acc_base;
  logic [7:0]  power_clamped;
  logic [7:0]  acc_sum;

  assign in_fire   = in_valid & in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_us_r  <= psmzc_pkg::DEBOUNCE_US_RST;
      max_restarts_r <= psmzc_pkg::MAX_RESTARTS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        psmzc_pkg::CFG_DEBOUNCE_US:  debounce_us_r  <= cfg_data;
        psmzc_pkg::CFG_MAX_RESTARTS: max_restarts_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Crossing processing
  always_comb begin
    gap_us   = in_timestamp_us - last_crossing_r;
    pass     = gap_us >= {16'd0, debounce_us_r};
    // rising enable clears the accumulator, even on a dropped crossing
    acc_base = (in_enable && !prev_enable_r) ? 7'd0 : acc_r;

    last_crossing_nxt = last_crossing_r;
    period_sum_nxt    = period_sum_r;
    period_count_nxt  = period_count_r;
    restart_count_nxt = restart_count_r;
    freq_known_nxt    = freq_known_r;
    is_60hz_nxt       = is_60hz_r;
    acc_nxt           = acc_base;

    sum_add = period_sum_r + gap_us;
    cnt_add = period_count_r + CntW'(1);

    if (pass) begin
      last_crossing_nxt = in_timestamp_us;
      if (!freq_known_r && (restart_count_r < max_restarts_r) &&
          (last_crossing_r != 32'd0)) begin
        period_sum_nxt   = sum_add;
        period_count_nxt = cnt_add;
        if (cnt_add >= CntTarget) begin
          if (sum_add >= Sum50Lo && sum_add < Sum50Hi) begin
            freq_known_nxt = 1'b1;
            is_60hz_nxt    = 1'b0;
          end else if (sum_add >= Sum60Lo && sum_add < Sum60Hi) begin
            freq_known_nxt = 1'b1;
            is_60hz_nxt    = 1'b1;
          end else begin
            // restart measurement
            period_sum_nxt   = 32'd0;
            period_count_nxt = '0;
            if (restart_count_r < psmzc_pkg::RESTART_LIMIT) begin
              restart_count_nxt = restart_count_r + 4'd1;
            end
          end
        end
      end
    end

    power_clamped = ({1'b0, in_power_percent} > psmzc_pkg::PERCENT_FULL) ?
                    psmzc_pkg::PERCENT_FULL : {1'b0, in_power_percent};
    acc_sum       = {1'b0, acc_base} + power_clamped;

    res.gate_on        = 1'b0;
    res.freq_known     = freq_known_nxt;
    res.mains_60hz     = freq_known_nxt & is_60hz_nxt;
    res.detect_gave_up = !freq_known_nxt && (restart_count_nxt >= max_restarts_r);

    if (pass && in_enable && (power_clamped != 8'd0)) begin
      if (acc_sum >= psmzc_pkg::PERCENT_FULL) begin
        res.gate_on = 1'b1;
        acc_nxt     = 7'(acc_sum - psmzc_pkg::PERCENT_FULL);
      end else begin
        acc_nxt     = acc_sum[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_crossing_r <= '0;
      acc_r           <= '0;
      prev_enable_r   <= 1'b0;
      period_sum_r    <= '0;
      period_count_r  <= '0;
      restart_count_r <= '0;
      freq_known_r    <= 1'b0;
      is_60hz_r       <= 1'b0;
    end else if (in_fire) begin
      last_crossing_r <= last_crossing_nxt;
      acc_r           <= acc_nxt;
      prev_enable_r   <= in_enable;
      period_sum_r    <= period_sum_nxt;
      period_count_r  <= period_count_nxt;
      restart_count_r <= restart_count_nxt;
      freq_known_r    <= freq_known_nxt;
      is_60hz_r       <= is_60hz_nxt;
    end
  end

  // Two-entry result buffer
  assign in_ready = !skid_valid_r;
  assign push     = in_fire & pass;
  assign pop      = out_valid_r & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || pop) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r  <= push;
        end
      end else if (push) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end
    if (push && out_valid_r && !pop) begin
      skid_data_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_gate_on        = out_data_r.gate_on;
  assign out_freq_known     = out_data_r.freq_known;
  assign out_mains_60hz     = out_data_r.mains_60hz;
  assign out_detect_gave_up = out_data_r.detect_gave_up;

  // Checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r) else $error("skid entry without output entry");

  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r < 7'd100) else $error("percent accumulator out of range");

  a_known_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    freq_known_r |=> freq_known_r) else $error("frequency classification lost");

  a_60hz_known: assert property (@(posedge clk) disable iff (!rst_n)
    is_60hz_r |-> freq_known_r) else $error("60 Hz flag without classification");

  // the count stays at target once the frequency is classified
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    period_count_r <= CntTarget) else $error("period count past target");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Testbench for psm_zero_cross_dimmer_core: random and directed crossing requests
// checked against a cycle-free predictor of gate and mains-detection results.
// Depends on psmzc_pkg and the core; no files or arguments.

class gate_predictor;
  logic [15:0] debounce_us;
  logic [3:0]  max_restarts;
  logic [31:0] last_crossing;
  logic [6:0]  accum;
  logic        prev_en;
  logic [31:0] period_sum;
  logic [5:0]  period_count;
  logic [3:0]  restart_count;
  logic        freq_known;
  logic        is_60hz;
  int unsigned periods_to_average;
  int unsigned mismatches;
  int unsigned results_checked;
  psmzc_pkg::result_t gate_results_due[$];

  function new(int unsigned periods);
    periods_to_average = periods;
    debounce_us   = psmzc_pkg::DEBOUNCE_US_RST;
    max_restarts  = psmzc_pkg::MAX_RESTARTS_RST;
    last_crossing = '0;
    accum         = '0;
    prev_en       = 1'b0;
    period_sum    = '0;
    period_count  = '0;
    restart_count = '0;
    freq_known    = 1'b0;
    is_60hz       = 1'b0;
    mismatches    = 0;
    results_checked = 0;
  endfunction

  function void write_reg(logic idx, logic [15:0] data);
    if (idx == psmzc_pkg::CFG_DEBOUNCE_US)
      debounce_us = data;
    else
      max_restarts = data[3:0];
  endfunction

  function int unsigned pending();
    return gate_results_due.size();
  endfunction

  function void take_crossing(logic [31:0] ts, logic [6:0] power, logic en);
    logic [31:0] gap_us;
    logic [31:0] mean;
    logic [7:0]  pw;
    logic [7:0]  acc;
    psmzc_pkg::result_t res;
    if (en && !prev_en)
      accum = '0;
    prev_en = en;
    gap_us = ts - last_crossing;
    if (gap_us < {16'd0, debounce_us})
      return;
    // accumulate periods until the mean can be classified
    if (!freq_known && restart_count < max_restarts && last_crossing != 32'd0) begin
      period_sum   = period_sum + gap_us;
      period_count = period_count + 6'd1;
      if (period_count >= periods_to_average) begin
        mean = period_sum / {26'd0, period_count};
        if (mean >= psmzc_pkg::MIN_50HZ_PERIOD && mean <= psmzc_pkg::MAX_50HZ_PERIOD) begin
          is_60hz    = 1'b0;
          freq_known = 1'b1;
        end else if (mean >= psmzc_pkg::MIN_60HZ_PERIOD &&
                     mean <= psmzc_pkg::MAX_60HZ_PERIOD) begin
          is_60hz    = 1'b1;
          freq_known = 1'b1;
        end else begin
          period_sum   = '0;
          period_count = '0;
          if (restart_count != psmzc_pkg::RESTART_LIMIT)
            restart_count = restart_count + 4'd1;
        end
      end
    end
    last_crossing = ts;
    pw = (power > 7'd100) ? 8'd100 : {1'b0, power};
    res = '0;
    if (pw != 8'd0 && en) begin
      acc = {1'b0, accum} + pw;
      if (acc >= 8'd100) begin
        res.gate_on = 1'b1;
        acc = acc - 8'd100;
      end
      accum = acc[6:0];
    end
    res.freq_known     = freq_known;
    res.mains_60hz     = freq_known & is_60hz;
    res.detect_gave_up = !freq_known && (restart_count >= max_restarts);
    gate_results_due.push_back(res);
  endfunction

  function void report(string what, psmzc_pkg::result_t want, psmzc_pkg::result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("result %0d %s: gate_on %0b/%0b freq_known %0b/%0b mains_60hz %0b/%0b %s %0b/%0b",
               results_checked, what, want.gate_on, got.gate_on, want.freq_known,
               got.freq_known, want.mains_60hz, got.mains_60hz, "gave_up (exp/act)",
               want.detect_gave_up, got.detect_gave_up);
  endfunction

  function void check_gate_result(psmzc_pkg::result_t got);
    psmzc_pkg::result_t want;
    if (gate_results_due.size() == 0) begin
      report("with none expected", '0, got);
    end else begin
      want = gate_results_due.pop_front();
      if (got.gate_on !== want.gate_on || got.freq_known !== want.freq_known ||
          got.mains_60hz !== want.mains_60hz || got.detect_gave_up !== want.detect_gave_up)
        report("mismatch", want, got);
    end
    results_checked++;
  endfunction
endclass

module tb;

  localparam int unsigned PERIODS_TO_AVERAGE = 20;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef enum {STIM_NOISE, MAINS_FAULTY, MAINS_NOMINAL} phase_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_timestamp_us = '0;
  logic [6:0]  in_power_percent = '0;
  logic        in_enable = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_gate_on;
  logic        out_freq_known;
  logic        out_mains_60hz;
  logic        out_detect_gave_up;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = psmzc_pkg::CFG_DEBOUNCE_US;
  logic [psmzc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  gate_predictor pred;
  logic [31:0]   mains_ts;
  logic          pump_en;
  int            fault_side;
  int            nominal_period;
  bit            nominal_exact;
  bit            sender_steady;

  always #5 clk = ~clk;

  psm_zero_cross_dimmer_core #(
    .PERIODS_TO_AVERAGE(PERIODS_TO_AVERAGE)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_timestamp_us    (in_timestamp_us),
    .in_power_percent   (in_power_percent),
    .in_enable          (in_enable),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_gate_on        (out_gate_on),
    .out_freq_known     (out_freq_known),
    .out_mains_60hz     (out_mains_60hz),
    .out_detect_gave_up (out_detect_gave_up),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  task automatic send_crossing(input logic [31:0] ts, input logic [6:0] pw, input logic en);
    int unsigned gap;
    gap = sender_steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_timestamp_us  <= ts;
    in_power_percent <= pw;
    in_enable        <= en;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred.take_crossing(ts, pw, en);
  endtask

  // Write both registers back to back; upper data bits of the restart limit are junk.
  task automatic set_registers(input logic [15:0] deb, input logic [3:0] lim);
    logic [15:0] lim_word;
    lim_word = 16'($urandom);
    lim_word[3:0] = lim;
    cfg_valid <= 1'b1;
    cfg_index <= psmzc_pkg::CFG_DEBOUNCE_US;
    cfg_data  <= deb;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pred.write_reg(psmzc_pkg::CFG_DEBOUNCE_US, deb);
    cfg_index <= psmzc_pkg::CFG_MAX_RESTARTS;
    cfg_data  <= lim_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pred.write_reg(psmzc_pkg::CFG_MAX_RESTARTS, lim_word);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pred.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input phase_kind_t kind, input int unsigned count);
    logic [31:0] ts;
    logic [6:0]  pw;
    logic        en;
    int          deb;
    int          step;
    bit          glitch;
    for (int i = 0; i < count; i++) begin
      deb = int'(pred.debounce_us);
      glitch = ($urandom_range(0, 7) == 0);
      if (kind == STIM_NOISE) begin
        ts = $urandom;
        pw = 7'($urandom_range(0, 127));
        en = 1'($urandom_range(0, 1));
      end else begin
        if ($urandom_range(0, 9) == 0)
          pump_en = ~pump_en;
        en = pump_en;
        pw = 7'(($urandom_range(0, 15) == 0) ? $urandom_range(101, 127)
                                              : $urandom_range(0, 100));
        if (kind == MAINS_FAULTY) begin
          // keep a whole measurement round on one side of the windows
          if (pred.period_count == 6'd0)
            fault_side = $urandom_range(0, 2);
          case (fault_side)
            0: step = ($urandom_range(0, 3) == 0) ? 15384 : $urandom_range(12000, 15384);
            1: step = ($urandom_range(0, 3) == 0) ? 22223 : $urandom_range(22223, 90000);
            default: step = $urandom_range(32'h0800_0000, 32'h1000_0000);
          endcase
        end else if (!pred.freq_known) begin
          step = nominal_exact ? nominal_period
                               : nominal_period + $urandom_range(0, 2000) - 1000;
        end else if ($urandom_range(0, 3) == 0) begin
          // hover around the debounce edge
          step = deb + $urandom_range(0, 4) - 2;
          if (step < 0)
            step = 0;
        end else begin
          step = deb + $urandom_range(0, 25000);
        end
        if (glitch) begin
          ts = mains_ts + $urandom_range(1, (deb > 1) ? deb - 1 : 1);
        end else if (kind == MAINS_NOMINAL && pred.freq_known &&
                     $urandom_range(0, 9) == 0) begin
          ts = $urandom;
        end else begin
          mains_ts = mains_ts + step;
          ts = mains_ts;
        end
      end
      send_crossing(ts, pw, en);
    end
  endtask

  initial begin
    int unsigned        stall;
    int unsigned        taken;
    psmzc_pkg::result_t got;
    taken = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = ((taken % 64) < 16) ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.gate_on        = out_gate_on;
      got.freq_known     = out_freq_known;
      got.mains_60hz     = out_mains_60hz;
      got.detect_gave_up = out_detect_gave_up;
      pred.check_gate_result(got);
      taken++;
    end
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    pred = new(PERIODS_TO_AVERAGE);
    mains_ts = '0;
    pump_en = 1'b1;
    fault_side = 0;
    sender_steady = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: early first crossing, clamping, enable edges, wrap
    send_crossing(32'd0,        7'd0,   1'b0);
    send_crossing(32'd14999,    7'd100, 1'b1);
    send_crossing(32'd15000,    7'd100, 1'b1);
    send_crossing(32'd35000,    7'd127, 1'b1);
    send_crossing(32'd35001,    7'd50,  1'b1);
    send_crossing(32'd55000,    7'd50,  1'b1);
    send_crossing(32'd75000,    7'd50,  1'b0);
    send_crossing(32'd75100,    7'd50,  1'b1);
    send_crossing(32'd95000,    7'd50,  1'b1);
    send_crossing(32'd115000,   7'd0,   1'b1);
    send_crossing(32'd135000,   7'd1,   1'b1);
    send_crossing(32'd155000,   7'd99,  1'b1);
    send_crossing(32'd175000,   7'd101, 1'b1);
    send_crossing(32'hFFFF_F000, 7'd64, 1'b1);
    send_crossing(32'h0000_2000, 7'd64, 1'b1);
    send_crossing(32'h0000_3000, 7'd64, 1'b1);
    send_crossing(32'h0000_0000, 7'd36, 1'b1);
    send_crossing(32'd20000,    7'd100, 1'b1);
    send_crossing(32'h7FFF_FFFF, 7'd127, 1'b0);
    send_crossing(32'h8000_0000, 7'd100, 1'b1);
    send_crossing(32'h8000_4000, 7'd42, 1'b1);
    drain_results();

    mains_ts = $urandom;
    // detection stopped outright, every crossing accepted
    set_registers(16'd0, 4'd0);
    run_phase(STIM_NOISE, 120);
    drain_results();

    // failed rounds until detection gives up
    set_registers(16'($urandom_range(1000, 12000)), 4'd3);
    run_phase(MAINS_FAULTY, 150);
    drain_results();

    // more failed rounds with the limit raised
    sender_steady = 1'b1;
    set_registers(16'($urandom_range(5000, 12000)), 4'd15);
    run_phase(MAINS_FAULTY, 150);
    drain_results();
    sender_steady = 1'b0;

    case ($urandom_range(0, 5))
      0: nominal_period = psmzc_pkg::MIN_50HZ_PERIOD;
      1: nominal_period = psmzc_pkg::MAX_50HZ_PERIOD;
      2: nominal_period = psmzc_pkg::MIN_60HZ_PERIOD;
      3: nominal_period = psmzc_pkg::MAX_60HZ_PERIOD;
      4: nominal_period = 20000;
      default: nominal_period = 16667;
    endcase
    nominal_exact = (nominal_period != 20000 && nominal_period != 16667);
    set_registers(16'($urandom_range(8000, 15000)), 4'd15);
    run_phase(MAINS_NOMINAL, 250);
    drain_results();

    set_registers(16'hFFFF, 4'd15);
    run_phase(MAINS_NOMINAL, 110);
    drain_results();

    sender_steady = 1'b1;
    set_registers(16'd0, 4'd0);
    run_phase(MAINS_NOMINAL, 110);
    drain_results();
    sender_steady = 1'b0;

    set_registers(16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)));
    run_phase(STIM_NOISE, 110);
    drain_results();

    set_registers(16'($urandom_range(1, 30000)), 4'd15);
    run_phase(MAINS_NOMINAL, 110);
    drain_results();

    set_registers(psmzc_pkg::DEBOUNCE_US_RST, psmzc_pkg::MAX_RESTARTS_RST);
    run_phase(MAINS_NOMINAL, 110);
    drain_results();
    repeat (10) @(posedge clk);

    if (pred.mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule

@@ filelist.f @@
sv/psmzc_pkg.sv
sv/psm_zero_cross_dimmer_core.sv
test/tb.sv
